@@ hdl/b64d_pkg.sv @@
`timescale 1ns / 1ps
// b64d_pkg: shared types, constants and the character map of the base64 decoder
// no dependencies

package b64d_pkg;

  localparam int BYTE_W   = 8;
  localparam int SEXTET_W = 6;
  localparam int GROUP_W  = 3 * SEXTET_W;   // first three sextets of a group
  localparam int TRIPLE_W = 4 * SEXTET_W;   // full group, three bytes
  localparam int NB_W     = 2;              // byte count of a group, 1..3

  // group command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CHAR_PAD   = 8'h3D;

  localparam logic [1:0] POS_THIRD = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  // one decoded group, or an error marker for a truncated text
  typedef struct packed {
    logic [TRIPLE_W-1:0] triple;
    logic [NB_W-1:0]     nbytes;
    logic                last;
    logic                error;
  } grp_cmd_t;

  // standard alphabet; pad and anything unknown give zero
  function automatic logic [SEXTET_W-1:0] sextet_of(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] d;
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
    end else if (c == CHAR_PLUS) begin
      d = 8'd62;
    end else if (c == CHAR_SLASH) begin
      d = 8'd63;
    end
    return d[SEXTET_W-1:0];
  endfunction

endpackage

@@ hdl/b64d_if.sv @@
`timescale 1ns / 1ps
// b64d_char_if, b64d_byte_if: valid/ready channels of the base64 decoder
// depends on b64d_pkg

interface b64d_char_if;
  import b64d_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_char;
  logic              in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface b64d_byte_if;
  import b64d_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              out_error;

  modport source (output valid, out_byte, out_last, out_error, input ready);
  modport sink   (input valid, out_byte, out_last, out_error, output ready);
endinterface

@@ hdl/b64d_front.sv @@
`timescale 1ns / 1ps
// b64d_front: maps characters to sextets and gathers them into group commands
// depends on b64d_pkg, b64d_if

module b64d_front (
  input  logic                clk,
  input  logic                rst_n,
  b64d_char_if.sink           in_chan,
  output logic                push,
  output b64d_pkg::grp_cmd_t  push_cmd,
  input  logic                q_full
);
  import b64d_pkg::*;

  logic [GROUP_W-1:0]  group_bits_r, group_bits_nxt;
  logic [1:0]          group_count_r, group_count_nxt;
  logic                third_pad_r, third_pad_nxt;
  logic                accept;
  logic                is_pad;
  logic [SEXTET_W-1:0] sextet;
  logic [NB_W-1:0]     drop;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && in_chan.ready;
  assign is_pad = (in_chan.in_char == CHAR_PAD);
  assign sextet = sextet_of(in_chan.in_char);

  always_comb begin
    group_bits_nxt  = group_bits_r;
    group_count_nxt = group_count_r;
    third_pad_nxt   = third_pad_r;
    push            = 1'b0;
    push_cmd        = '0;
    drop            = {1'b0, in_chan.in_last && is_pad}
                    + {1'b0, in_chan.in_last && third_pad_r};
    if (accept) begin
      if (group_count_r != POS_FOURTH) begin
        group_bits_nxt  = {group_bits_r[GROUP_W-SEXTET_W-1:0], sextet};
        group_count_nxt = group_count_r + 2'd1;
        if (group_count_r == POS_THIRD) begin
          third_pad_nxt = is_pad;
        end
        if (in_chan.in_last) begin
          // text ended inside a group
          push            = 1'b1;
          push_cmd.nbytes = NB_W'(1);
          push_cmd.last   = 1'b1;
          push_cmd.error  = 1'b1;
          group_bits_nxt  = '0;
          group_count_nxt = '0;
          third_pad_nxt   = 1'b0;
        end
      end else begin
        push            = 1'b1;
        push_cmd.triple = {group_bits_r, sextet};
        push_cmd.nbytes = NB_W'(3) - drop;
        push_cmd.last   = in_chan.in_last;
        group_bits_nxt  = '0;
        group_count_nxt = '0;
        third_pad_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_bits_r  <= '0;
      group_count_r <= '0;
      third_pad_r   <= 1'b0;
    end else begin
      group_bits_r  <= group_bits_nxt;
      group_count_r <= group_count_nxt;
      third_pad_r   <= third_pad_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_clears_group: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.in_last) |=> (group_count_r == '0 && !third_pad_r))
    else $error("group state not cleared after last character");
`endif

endmodule

@@ hdl/b64d_queue.sv @@
`timescale 1ns / 1ps
// b64d_queue: short fifo of group commands between front and back
// depends on b64d_pkg

module b64d_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64d_pkg::grp_cmd_t push_cmd,
  output logic               full,
  input  logic               pop,
  output b64d_pkg::grp_cmd_t pop_cmd,
  output logic               empty
);
  import b64d_pkg::*;

  grp_cmd_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full command queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty command queue");
`endif

endmodule

@@ hdl/b64d_back.sv @@
`timescale 1ns / 1ps
// b64d_back: unpacks group commands into byte transactions, one per cycle while out_chan is ready
// depends on b64d_pkg, b64d_if

module b64d_back (
  input  logic               clk,
  input  logic               rst_n,
  input  b64d_pkg::grp_cmd_t pop_cmd,
  input  logic               q_empty,
  output logic               pop,
  b64d_byte_if.source        out_chan
);
  import b64d_pkg::*;

  grp_cmd_t        cur_r;
  logic            busy_r;
  logic [NB_W-1:0] idx_r;
  logic            fire;
  logic            final_byte;

  assign final_byte = (idx_r == cur_r.nbytes - NB_W'(1));
  assign fire       = busy_r && out_chan.ready;
  assign pop        = !q_empty && (!busy_r || (fire && final_byte));

  assign out_chan.valid     = busy_r;
  assign out_chan.out_last  = cur_r.last && final_byte;
  assign out_chan.out_error = cur_r.error;

  always_comb begin
    unique case (idx_r)
      2'd0:    out_chan.out_byte = cur_r.triple[3*BYTE_W-1:2*BYTE_W];
      2'd1:    out_chan.out_byte = cur_r.triple[2*BYTE_W-1:BYTE_W];
      2'd2:    out_chan.out_byte = cur_r.triple[BYTE_W-1:0];
      default: out_chan.out_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire && final_byte) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (fire) begin
      idx_r <= idx_r + NB_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_error_is_lone_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.out_error) |-> (out_chan.out_last && out_chan.out_byte == '0))
    else $error("error transaction without last flag or with data");
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < cur_r.nbytes))
    else $error("byte index past group byte count");
`endif

endmodule

@@ hdl/base64_stream_decoder_core.sv @@
`timescale 1ns / 1ps
// base64_stream_decoder_core: top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back
//
//   channel   | dir | payload                           | transaction
//   in_chan   | in  | in_char[7:0], in_last             | one text character
//   out_chan  | out | out_byte[7:0], out_last, out_error | one decoded byte or error
//
// one character accepted per cycle; the front stalls only when the 4-entry
// group queue is full
// one byte delivered per cycle while out_chan is ready; a group gives 1 to 3 bytes
// the first byte of a group is valid once its command is written into the queue
// and then popped into the back register; the back pops only when idle or when
// the final byte of its current group is taken
// rst_n is synchronous, active low; it clears group state, queue and output
// a stalled output holds its transaction while the front keeps filling the queue

module base64_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  b64d_char_if.sink   in_chan,
  b64d_byte_if.source out_chan
);
  import b64d_pkg::*;

  // front to queue
  logic     push;
  grp_cmd_t push_cmd;
  logic     q_full;

  // queue to back
  logic     pop;
  grp_cmd_t pop_cmd;
  logic     q_empty;

  // character map and group gathering
  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // decouples the character side from the byte side
  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // byte unpacking and output register
  b64d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_cmd  (pop_cmd),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

@@ tb/tb_base64_stream_decoder_core.sv @@
`timescale 1ns / 1ps
// tb_base64_stream_decoder_core: self-checking bench for the streaming base64 decoder
// depends on b64d_pkg, b64d_if and base64_stream_decoder_core

module tb_base64_stream_decoder_core;
  import b64d_pkg::*;

  localparam int TEXT_CHARS   = 420;     // stimulus stops once this many are queued
  localparam int CALM_TAIL    = 60;      // last characters go through with no idling
  localparam int SETTLE_WAIT  = 20;      // cycles after the last byte, well past latency
  localparam int CYCLE_LIMIT  = 200000;  // watchdog bound on the whole run
  localparam int REPORT_LIMIT = 10;

  // one pending character; hold_off makes the sender wait for the output to drain
  typedef struct {
    logic [BYTE_W-1:0] ch;
    logic              last;
    bit                hold_off;
  } text_char_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } decoded_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  b64d_char_if char_ch ();
  b64d_byte_if byte_ch ();

  base64_stream_decoder_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (char_ch),
    .out_chan(byte_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_char_t    text_q[$];       // characters not yet offered to the decoder
  decoded_byte_t expected_bytes[$];

  // decoder state as the bench tracks it
  logic [GROUP_W-1:0] grp_sextets;
  logic [1:0]         grp_pos;
  logic               third_pad;

  int total_chars;
  int chars_done;
  int bytes_checked;
  int error_results;
  int texts_queued = 0;
  int fail_count;
  int cycle_count;
  int send_gap;
  int recv_stall;

  function automatic logic [SEXTET_W-1:0] b64_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    v = '0;
    if (c >= "A" && c <= "Z") begin
      v = c - "A";
    end else if (c >= "a" && c <= "z") begin
      v = c - "a" + 8'd26;
    end else if (c >= "0" && c <= "9") begin
      v = c - "0" + 8'd52;
    end else if (c == CHAR_PLUS) begin
      v = 8'd62;
    end else if (c == CHAR_SLASH) begin
      v = 8'd63;
    end
    return v[SEXTET_W-1:0];
  endfunction

  // inverse map, used to build well-formed text
  function automatic logic [BYTE_W-1:0] b64_char(input int idx);
    logic [BYTE_W-1:0] c;
    if (idx < 26) begin
      c = BYTE_W'(8'h41 + idx);
    end else if (idx < 52) begin
      c = BYTE_W'(8'h61 + idx - 26);
    end else if (idx < 62) begin
      c = BYTE_W'(8'h30 + idx - 52);
    end else if (idx == 62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  function automatic void clear_group();
    grp_sextets = '0;
    grp_pos     = '0;
    third_pad   = 1'b0;
  endfunction

  // advance the tracked state by one accepted character and queue what it yields
  function automatic void decode_char(input logic [BYTE_W-1:0] c, input logic last);
    logic [TRIPLE_W-1:0] triple;
    int                  nbytes;
    logic                is_pad;
    decoded_byte_t       b;
    is_pad = (c == CHAR_PAD);
    if (grp_pos != POS_FOURTH) begin
      grp_sextets = {grp_sextets[GROUP_W-SEXTET_W-1:0], b64_value(c)};
      if (grp_pos == POS_THIRD) begin
        third_pad = is_pad;
      end
      grp_pos = grp_pos + 2'd1;
      // text ended partway through a group
      if (last) begin
        b.data = '0;
        b.last = 1'b1;
        b.err  = 1'b1;
        expected_bytes.push_back(b);
        clear_group();
      end
    end else begin
      triple = {grp_sextets, b64_value(c)};
      nbytes = 3;
      // padding only trims bytes in the final group
      if (last) begin
        if (is_pad) begin
          nbytes--;
        end
        if (third_pad) begin
          nbytes--;
        end
      end
      for (int k = 0; k < nbytes; k++) begin
        b.data = triple[TRIPLE_W-1-8*k -: 8];
        b.last = last && (k == nbytes - 1);
        b.err  = 1'b0;
        expected_bytes.push_back(b);
      end
      clear_group();
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  function automatic void queue_char(input logic [BYTE_W-1:0] c, input logic last,
                                     input bit hold_off = 1'b0);
    text_char_t t;
    t.ch       = c;
    t.last     = last;
    t.hold_off = hold_off;
    text_q.push_back(t);
    if (last) begin
      texts_queued++;
    end
  endfunction

  // queue a string of characters; the final one carries last when asked
  function automatic void queue_text(input string s, input bit ends_text);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i], ends_text && (i == s.len() - 1));
    end
  endfunction

  function automatic logic [BYTE_W-1:0] noise_char();
    if ($urandom_range(0, 3) == 0) begin
      return CHAR_PAD;
    end
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // one random text: mostly well-formed, some truncated, some pure noise
  function automatic void queue_random_text(input bit hold_off);
    int kind;
    int groups;
    int pads;
    int nchars;
    int idx;
    logic [BYTE_W-1:0] txt[$];
    kind   = $urandom_range(0, 9);
    groups = $urandom_range(0, 4);
    if ($urandom_range(0, 15) == 0) begin
      groups = $urandom_range(5, 12);
    end
    if (kind <= 7) begin
      for (int g = 0; g < groups; g++) begin
        for (int j = 0; j < 4; j++) begin
          // stray pad or junk inside a body group now and then
          if ($urandom_range(0, 31) == 0) begin
            txt.push_back(noise_char());
          end else begin
            txt.push_back(b64_char($urandom_range(0, 63)));
          end
        end
      end
    end
    if (kind <= 6) begin
      // closing group with zero, one or two pads, or a pad on the third only
      pads = $urandom_range(0, 2);
      for (int j = 0; j < 4 - pads; j++) begin
        txt.push_back(b64_char($urandom_range(0, 63)));
      end
      for (int j = 0; j < pads; j++) begin
        txt.push_back(CHAR_PAD);
      end
      if (pads == 0 && $urandom_range(0, 7) == 0) begin
        txt[txt.size() - 2] = CHAR_PAD;
      end
    end else if (kind == 7) begin
      // truncated text
      nchars = $urandom_range(1, 3);
      for (int j = 0; j < nchars; j++) begin
        txt.push_back(($urandom_range(0, 4) == 0) ? CHAR_PAD : b64_char($urandom_range(0, 63)));
      end
    end else begin
      nchars = $urandom_range(1, 14);
      for (int j = 0; j < nchars; j++) begin
        txt.push_back(noise_char());
      end
    end
    for (idx = 0; idx < txt.size(); idx++) begin
      queue_char(txt[idx], idx == txt.size() - 1, hold_off && idx == 0);
    end
  endfunction

  // idling stops near the end of the run
  function automatic bit tail_phase();
    return text_q.size() < CALM_TAIL;
  endfunction

  // every input known from time zero
  initial begin
    rst_n           = 1'b0;
    char_ch.valid   = 1'b0;
    char_ch.in_char = '0;
    char_ch.in_last = 1'b0;
    byte_ch.ready   = 1'b0;
    chars_done      = 0;
    bytes_checked   = 0;
    error_results   = 0;
    fail_count      = 0;
    cycle_count     = 0;
    send_gap        = 0;
    recv_stall      = 0;
    clear_group();
  end

  // driver: offers one character per transaction, with random gaps
  always @(posedge clk) begin
    text_char_t t;
    if (!rst_n) begin
      char_ch.valid <= 1'b0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        decode_char(char_ch.in_char, char_ch.in_last);
        chars_done++;
      end
      if (char_ch.valid && !char_ch.ready) begin
        // transaction still pending, keep it steady
      end else if (send_gap > 0) begin
        send_gap--;
        char_ch.valid <= 1'b0;
      end else if (text_q.size() > 0 && text_q[0].hold_off && expected_bytes.size() > 0) begin
        // sender waits until the decoder has delivered everything owed
        char_ch.valid <= 1'b0;
      end else if (text_q.size() > 0 && !tail_phase() && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        char_ch.valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        t = text_q.pop_front();
        char_ch.valid   <= 1'b1;
        char_ch.in_char <= t.ch;
        char_ch.in_last <= t.last;
      end else begin
        char_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: checks each output transaction and stalls ready in bursts
  always @(posedge clk) begin
    decoded_byte_t want;
    if (!rst_n) begin
      byte_ch.ready <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %02h last %0b error %0b",
                                  byte_ch.out_byte, byte_ch.out_last, byte_ch.out_error));
        end else begin
          want = expected_bytes.pop_front();
          if (byte_ch.out_byte !== want.data || byte_ch.out_last !== want.last ||
              byte_ch.out_error !== want.err) begin
            note_mismatch($sformatf(
              "result %0d expected byte %02h last %0b error %0b, got %02h %0b %0b",
              bytes_checked, want.data, want.last, want.err,
              byte_ch.out_byte, byte_ch.out_last, byte_ch.out_error));
          end
          if (want.err) begin
            error_results++;
          end
          bytes_checked++;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        byte_ch.ready <= 1'b0;
      end else if (!tail_phase() && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 18) - 1;
        byte_ch.ready <= 1'b0;
      end else begin
        byte_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d characters sent, %0d results owed",
               cycle_count, chars_done, total_chars, expected_bytes.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // directed texts
    queue_text("Az9+", 1'b0);                       // alphabet extremes, plus
    queue_char(CHAR_PAD, 1'b0);                     // pad in first and third of a body group,
    queue_char(CHAR_SLASH, 1'b0);                   // slash, and junk above the alphabet
    queue_char(CHAR_PAD, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_text("Za0=", 1'b1);                       // one pad: two bytes
    queue_char(8'h00, 1'b0);                        // two-pad final group, junk chars
    queue_char(8'h80, 1'b0);
    queue_char(CHAR_PAD, 1'b0);
    queue_char(CHAR_PAD, 1'b1);
    queue_text("QE=w", 1'b1);                       // pad on the third only
    queue_text("a", 1'b1);                          // truncated after one, two, three chars
    queue_text("bc", 1'b1);
    queue_text("d+=", 1'b1);

    // random texts; the first one and those begun near the middle wait for a drained output
    queue_random_text(1'b1);
    while (text_q.size() < TEXT_CHARS) begin
      queue_random_text(text_q.size() >= TEXT_CHARS / 2 && text_q.size() < TEXT_CHARS / 2 + 8);
    end
    total_chars = text_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_done < total_chars) begin
      @(posedge clk);
    end
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("decoded %0d texts from %0d characters", texts_queued, total_chars);
    $display("checked %0d results, %0d of them truncation errors, %0d mismatches",
             bytes_checked, error_results, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
